[rtl/core/easter_and_feast_date_core_macros.svh]
// Assertion helpers for the easter/feast date core checker.
`ifndef EASTER_AND_FEAST_DATE_CORE_MACROS_SVH
`define EASTER_AND_FEAST_DATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/efd_pkg.sv]
package efd_pkg;

  localparam int YEAR_W   = 14;
  localparam int OFF_W    = 8;
  localparam int DIVR_W   = 9;
  localparam int FD_W     = 8;
  localparam int RECIP_W  = 23;
  localparam int RECIP_SH = 24;
  localparam int PROD_W   = YEAR_W + RECIP_W;

  localparam logic [OFF_W-1:0] OFFSET_RESET = 8'd49;
  localparam logic [OFF_W-1:0] OFFSET_MAX   = 8'd200;

  // Constant divisors of the computus.
  localparam logic [DIVR_W-1:0] DIV_GOLDEN  = 9'd19;
  localparam logic [DIVR_W-1:0] DIV_CENTURY = 9'd100;
  localparam logic [DIVR_W-1:0] DIV_F       = 9'd25;
  localparam logic [DIVR_W-1:0] DIV_G       = 9'd3;
  localparam logic [DIVR_W-1:0] DIV_EPACT   = 9'd30;
  localparam logic [DIVR_W-1:0] DIV_WEEK    = 9'd7;
  localparam logic [DIVR_W-1:0] DIV_M       = 9'd451;
  localparam logic [DIVR_W-1:0] DIV_MONTH   = 9'd31;

  // ceil(2^24 / d); the quotient is exact for every 14-bit dividend.
  localparam logic [RECIP_W-1:0] RCP_GOLDEN  = 23'd883012;
  localparam logic [RECIP_W-1:0] RCP_CENTURY = 23'd167773;
  localparam logic [RECIP_W-1:0] RCP_F       = 23'd671089;
  localparam logic [RECIP_W-1:0] RCP_G       = 23'd5592406;
  localparam logic [RECIP_W-1:0] RCP_EPACT   = 23'd559241;
  localparam logic [RECIP_W-1:0] RCP_WEEK    = 23'd2396746;
  localparam logic [RECIP_W-1:0] RCP_M       = 23'd37201;
  localparam logic [RECIP_W-1:0] RCP_MONTH   = 23'd541201;

  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_REM,
    ST_STORE,
    ST_WALK,
    ST_DONE
  } state_t;

  // Which division the shared multiplier is working on.
  typedef enum logic [2:0] {
    PH_A,
    PH_B,
    PH_F,
    PH_G,
    PH_H,
    PH_L,
    PH_M,
    PH_E
  } phase_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      MON_FEB:                          len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default:                          len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/easter_and_feast_date_core.sv]
// Channel | Ports                                       | Handshake
// --------+---------------------------------------------+-----------------------------------
// in      | in_year                                     | start && !busy takes an item
// out     | out_paschal_month/day, out_feast_month/day | out_valid, one cycle, no stall
// cfg     | cfg_offset_days                             | cfg_valid && cfg_ready (ready high)
//
// Sequence: the shared multiplier does 8 constant divisions by reciprocal, each in
//   four steps (load, quotient multiply, back multiply, store), then walks the
//   feast date one month per cycle (n = months walked, 0..7) plus the final walk check.
//   The strobe comes in the done state; no new item is taken until the core is
//   back in idle after it.
// Reset: synchronous, active low; offset returns to 49, sequencer to idle.
// Stalls: none on the output side, the receiver must take each item.
module easter_and_feast_date_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [efd_pkg::YEAR_W-1:0] in_year,
  output logic                       out_valid,
  output logic [2:0]                 out_paschal_month,
  output logic [4:0]                 out_paschal_day,
  output logic [3:0]                 out_feast_month,
  output logic [4:0]                 out_feast_day,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [efd_pkg::OFF_W-1:0]  cfg_offset_days
);
  import efd_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [OFF_W-1:0]  offset_r;
  logic [YEAR_W-1:0] year_r;

  // Shared multiplier: dividend times reciprocal, then quotient times divisor
  logic [YEAR_W-1:0]  dvd_r;     // dividend of the current division
  logic [PROD_W-1:0]  prod_r;
  logic [YEAR_W-1:0]  quo_r;
  logic [YEAR_W-1:0]  quo_w;
  logic [YEAR_W-1:0]  rem_w;
  logic [YEAR_W-1:0]  dividend;
  logic [DIVR_W-1:0]  divisor;
  logic [RECIP_W-1:0] recip;
  logic [YEAR_W-1:0]  mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  // Computus terms
  logic [4:0] a_r;   // year mod 19
  logic [7:0] b_r;   // century
  logic [6:0] c_r;   // year of century
  logic [2:0] f_r;
  logic [5:0] g_r;
  logic [4:0] h_r;   // epact-like term
  logic [2:0] l_r;   // weekday correction
  logic       m_r;

  logic [2:0]      em_r;
  logic [4:0]      ed_r;
  logic [3:0]      fm_r;
  logic [FD_W-1:0] fd_r;

  logic [OFF_W-1:0] off_sat;
  logic             leap;
  logic [4:0]       cur_len;
  logic             walk_more;

  logic [YEAR_W-1:0] a_x, b_x, c_x, f_x, g_x, h_x, l_x, m_x;

  assign a_x = YEAR_W'(a_r);
  assign b_x = YEAR_W'(b_r);
  assign c_x = YEAR_W'(c_r);
  assign f_x = YEAR_W'(f_r);
  assign g_x = YEAR_W'(g_r);
  assign h_x = YEAR_W'(h_r);
  assign l_x = YEAR_W'(l_r);
  assign m_x = YEAR_W'(m_r);

  // Operand select; every dividend stays non-negative and below 2^14.
  always_comb begin
    unique case (phase_r)
      PH_A: begin
        dividend = year_r;
        divisor  = DIV_GOLDEN;
        recip    = RCP_GOLDEN;
      end
      PH_B: begin
        dividend = year_r;
        divisor  = DIV_CENTURY;
        recip    = RCP_CENTURY;
      end
      PH_F: begin
        dividend = b_x + YEAR_W'(8);
        divisor  = DIV_F;
        recip    = RCP_F;
      end
      PH_G: begin
        dividend = b_x - f_x + YEAR_W'(1);
        divisor  = DIV_G;
        recip    = RCP_G;
      end
      PH_H: begin
        // 19a + b + 15 + 600 - b/4 - g
        dividend = YEAR_W'(19) * a_x + b_x + YEAR_W'(615) - (b_x >> 2) - g_x;
        divisor  = DIV_EPACT;
        recip    = RCP_EPACT;
      end
      PH_L: begin
        // 32 + 35 + 2(b mod 4) + 2(c/4) - h - c mod 4
        dividend = YEAR_W'(67) + YEAR_W'({b_r[1:0], 1'b0}) + YEAR_W'({c_r[6:2], 1'b0})
                   - h_x - YEAR_W'(c_r[1:0]);
        divisor  = DIV_WEEK;
        recip    = RCP_WEEK;
      end
      PH_M: begin
        dividend = a_x + YEAR_W'(11) * h_x + YEAR_W'(22) * l_x;
        divisor  = DIV_M;
        recip    = RCP_M;
      end
      PH_E: begin
        // month * 31 + day - 1
        dividend = h_x + l_x + YEAR_W'(114) - YEAR_W'(7) * m_x;
        divisor  = DIV_MONTH;
        recip    = RCP_MONTH;
      end
      default: begin
        dividend = year_r;
        divisor  = DIV_MONTH;
        recip    = RCP_MONTH;
      end
    endcase
  end

  // Quotient is the product's top bits; remainder comes from the back multiply.
  assign quo_w = YEAR_W'(prod_r[PROD_W-1:RECIP_SH]);
  assign mul_a = (state_r == ST_REM) ? quo_w : dvd_r;
  assign mul_b = (state_r == ST_REM) ? RECIP_W'(divisor) : recip;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rem_w = dvd_r - prod_r[YEAR_W-1:0];

  assign off_sat = (offset_r > OFFSET_MAX) ? OFFSET_MAX : offset_r;

  // y mod 400 == 0 reduces to century mod 4 == 0 when year of century is 0.
  assign leap      = (c_r == 7'd0) ? (b_r[1:0] == 2'b00) : (year_r[1:0] == 2'b00);
  assign cur_len   = month_len(fm_r, leap);
  assign walk_more = (fm_r < MON_DEC) && (FD_W'(cur_len) < fd_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_REM;
      ST_REM:   state_nxt = ST_STORE;
      ST_STORE: state_nxt = (phase_r == PH_E) ? ST_WALK : ST_LOAD;
      ST_WALK:  if (!walk_more) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    cfg_ready = 1'b1;
  end

  assign out_paschal_month = em_r;
  assign out_paschal_day   = ed_r;
  assign out_feast_month   = fm_r;
  assign out_feast_day     = fd_r[4:0];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_A;
      offset_r <= OFFSET_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) offset_r <= cfg_offset_days;
      unique case (state_r)
        ST_IDLE:  phase_r <= PH_A;
        ST_STORE: begin
          unique case (phase_r)
            PH_A:    phase_r <= PH_B;
            PH_B:    phase_r <= PH_F;
            PH_F:    phase_r <= PH_G;
            PH_G:    phase_r <= PH_H;
            PH_H:    phase_r <= PH_L;
            PH_L:    phase_r <= PH_M;
            PH_M:    phase_r <= PH_E;
            default: phase_r <= PH_A;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) year_r <= in_year;

    if (state_r == ST_LOAD) dvd_r <= dividend;
    if (state_r == ST_DIV || state_r == ST_REM) prod_r <= mul_p;
    if (state_r == ST_REM) quo_r <= quo_w;

    if (state_r == ST_STORE) begin
      unique case (phase_r)
        PH_A: a_r <= rem_w[4:0];
        PH_B: begin
          b_r <= quo_r[7:0];
          c_r <= rem_w[6:0];
        end
        PH_F: f_r <= quo_r[2:0];
        PH_G: g_r <= quo_r[5:0];
        PH_H: h_r <= rem_w[4:0];
        PH_L: l_r <= rem_w[2:0];
        PH_M: m_r <= quo_r[0];
        PH_E: begin
          em_r <= quo_r[2:0];
          ed_r <= rem_w[4:0] + 5'd1;
          fm_r <= {1'b0, quo_r[2:0]};
          fd_r <= FD_W'(rem_w[4:0]) + FD_W'(1) + FD_W'(off_sat);
        end
        default: ;
      endcase
    end

    // Month walk: one month per cycle.
    if (state_r == ST_WALK && walk_more) begin
      fd_r <= fd_r - FD_W'(cur_len);
      fm_r <= fm_r + 4'd1;
    end
  end

endmodule

[rtl/core/efd_checker.sv]
`include "easter_and_feast_date_core_macros.svh"

module efd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_paschal_month,
  input logic [4:0] out_paschal_day,
  input logic [3:0] out_feast_month,
  input logic [4:0] out_feast_day
);
  import efd_pkg::*;

  logic paschal_ok;
  logic feast_ok;

  // Easter always falls on March 22 .. April 25.
  assign paschal_ok = (out_paschal_month == 3'd3 && out_paschal_day >= 5'd22) ||
                      (out_paschal_month == 3'd4 && out_paschal_day <= 5'd25);

  // Feast month never precedes Easter's, stays within December, and the feast day is non-zero.
  assign feast_ok = (out_feast_day != 5'd0) && (out_feast_month <= MON_DEC) &&
                    ({1'b0, out_paschal_month} <= out_feast_month);

  // Accepted item keeps the core busy until its result is out.
  `EFD_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised")

  // Result strobe marks the end of the item, core free next cycle.
  `EFD_ASSERT_NEXT(a_done_free, clk, rst_n, out_valid, !busy && !out_valid, "core not free")

  `EFD_ASSERT_NOW(a_paschal_window, clk, rst_n, out_valid, paschal_ok, "Easter out of window")

  `EFD_ASSERT_NOW(a_feast_order, clk, rst_n, out_valid, feast_ok, "feast date invalid")

endmodule

bind easter_and_feast_date_core efd_checker u_efd_checker (.*);

[tb/sv/easter_and_feast_date_checker.sv]
`timescale 1ns / 100ps

module easter_and_feast_date_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [efd_pkg::YEAR_W-1:0] in_year,
  input  logic                       out_valid,
  input  logic [2:0]                 out_paschal_month,
  input  logic [4:0]                 out_paschal_day,
  input  logic [3:0]                 out_feast_month,
  input  logic [4:0]                 out_feast_day,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [efd_pkg::OFF_W-1:0]  cfg_offset_days,
  output int                         mismatches,
  output int                         dates_pending
);

  typedef struct packed {
    logic [2:0] paschal_month;
    logic [4:0] paschal_day;
    logic [3:0] feast_month;
    logic [4:0] feast_day;
  } feast_dates_t;

  feast_dates_t                dates_due[$];
  logic [efd_pkg::OFF_W-1:0]   offset_q;
  int                          fail_count = 0;

  function automatic int days_in_month(input int yr, input int mon);
    bit leap;
    leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    if (mon == efd_pkg::MON_FEB) return leap ? 29 : 28;
    if (mon == efd_pkg::MON_APR || mon == efd_pkg::MON_JUN ||
        mon == efd_pkg::MON_SEP || mon == efd_pkg::MON_NOV) return 30;
    return 31;
  endfunction

  // Anonymous Gregorian computus, then the month walk by the offset.
  function automatic feast_dates_t predict_dates(input logic [efd_pkg::YEAR_W-1:0] year_in,
                                                 input logic [efd_pkg::OFF_W-1:0]  offs);
    int           yr, golden, cent, yoc, cent_q, cent_r, f_corr, g_corr, epact;
    int           yoc_q, yoc_r, wday, m_corr, base, fmon, fday, step, eff_off;
    feast_dates_t r;
    yr     = int'(year_in);
    golden = yr % 19;
    cent   = yr / 100;
    yoc    = yr % 100;
    cent_q = cent / 4;
    cent_r = cent % 4;
    f_corr = (cent + 8) / 25;
    g_corr = (cent - f_corr + 1) / 3;
    epact  = (19 * golden + cent + 15 + 600 - cent_q - g_corr) % 30;
    yoc_q  = yoc / 4;
    yoc_r  = yoc % 4;
    wday   = (32 + 2 * cent_r + 2 * yoc_q + 35 - epact - yoc_r) % 7;
    m_corr = (golden + 11 * epact + 22 * wday) / 451;
    base   = epact + wday + 114 - 7 * m_corr;
    eff_off = (offs > efd_pkg::OFFSET_MAX) ? int'(efd_pkg::OFFSET_MAX) : int'(offs);
    r.paschal_month = 3'(base / 31);
    r.paschal_day   = 5'(base % 31 + 1);
    fmon = base / 31;
    fday = base % 31 + 1 + eff_off;
    for (step = 0; step < 12 && fmon < efd_pkg::MON_DEC && fday > days_in_month(yr, fmon);
         step++) begin
      fday -= days_in_month(yr, fmon);
      fmon++;
    end
    r.feast_month = 4'(fmon);
    r.feast_day   = 5'(fday);
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    feast_dates_t due;
    if (!rst_n) begin
      offset_q <= efd_pkg::OFFSET_RESET;
      dates_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) offset_q <= cfg_offset_days;
      if (start && !busy) dates_due.push_back(predict_dates(in_year, offset_q));
      if (out_valid) begin
        if (dates_due.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none actual %0d/%0d feast %0d/%0d", $time,
                   out_paschal_month, out_paschal_day, out_feast_month, out_feast_day);
        end else begin
          due = dates_due.pop_front();
          check_field("paschal_month", int'(due.paschal_month), int'(out_paschal_month));
          check_field("paschal_day", int'(due.paschal_day), int'(out_paschal_day));
          check_field("feast_month", int'(due.feast_month), int'(out_feast_month));
          check_field("feast_day", int'(due.feast_day), int'(out_feast_day));
        end
      end
    end
    mismatches    <= fail_count;
    dates_pending <= dates_due.size();
  end

endmodule

[tb/sv/tb_easter_and_feast_date_core.sv]
`timescale 1ns / 100ps

module tb_easter_and_feast_date_core;

  // Limit is many times the worst item plus the longest sender gap.
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int NUM_PHASES      = 10;
  localparam int NUM_LANDMARKS   = 14;
  // Longer than the block's worst latency, with 7 months walked.
  localparam int DRAIN_CYCLES    = 150;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic [efd_pkg::YEAR_W-1:0] in_year = '0;
  logic                       cfg_valid = 1'b0;
  logic [efd_pkg::OFF_W-1:0]  cfg_offset_days = '0;

  logic       busy;
  logic       out_valid;
  logic [2:0] out_paschal_month;
  logic [4:0] out_paschal_day;
  logic [3:0] out_feast_month;
  logic [4:0] out_feast_day;
  logic       cfg_ready;

  int mismatches;
  int dates_pending;
  int cycle_count = 0;

  // Directed years: field extremes and bit patterns, earliest Easter (Mar 22),
  // latest Easter (Apr 25), both correction branches that pull Apr 26 / Apr 25
  // back a week, and century leap / non-leap years.
  int landmark_years [NUM_LANDMARKS] = '{
    0, 16383, 1583, 9999, 1818, 2285, 1886, 1943, 1981, 1954, 2000, 1900, 10922, 5461
  };

  easter_and_feast_date_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_year           (in_year),
    .out_valid         (out_valid),
    .out_paschal_month (out_paschal_month),
    .out_paschal_day   (out_paschal_day),
    .out_feast_month   (out_feast_month),
    .out_feast_day     (out_feast_day),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_offset_days   (cfg_offset_days)
  );

  // Watches all three channels, predicts every accepted item, counts failures.
  easter_and_feast_date_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_year           (in_year),
    .out_valid         (out_valid),
    .out_paschal_month (out_paschal_month),
    .out_paschal_day   (out_paschal_day),
    .out_feast_month   (out_feast_month),
    .out_feast_day     (out_feast_day),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_offset_days   (cfg_offset_days),
    .mismatches        (mismatches),
    .dates_pending     (dates_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one year and hold it until the block takes it (start && !busy at an edge).
  // start is left high so back-to-back items need no extra edge on start.
  task automatic send_year(input int yr);
    start   <= 1'b1;
    in_year <= yr[efd_pkg::YEAR_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender gap with start low; n of zero leaves start as it is.
  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending until every predicted date has come back and the block is idle.
  // The first edge lets the checker count an item taken at the current edge.
  task automatic wait_dates_drained();
    start <= 1'b0;
    @(posedge clk);
    while (dates_pending != 0 || busy) @(posedge clk);
  endtask

  // Offset changes only while nothing is in flight.
  task automatic write_offset(input int offs);
    wait_dates_drained();
    cfg_valid       <= 1'b1;
    cfg_offset_days <= offs[efd_pkg::OFF_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly the intended range, some years below 1583 and above 9999.
  function automatic int random_year();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return $urandom_range(0, 1582);
    if (pick == 1) return $urandom_range(10000, 16383);
    return $urandom_range(1583, 9999);
  endfunction

  initial begin : stimulus
    int phase_offsets [NUM_PHASES];
    int phase, sent, burst, n, pick;

    // Offset extremes first (zero, the cap, all ones and just past the cap),
    // then near-extremes, the reset value again and a few random settings.
    phase_offsets = '{0, 200, 255, 201, 1, 199, 49, 0, 0, 0};
    for (phase = 7; phase < NUM_PHASES; phase++) phase_offsets[phase] = $urandom_range(0, 255);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed years under the reset offset (Whitsunday).
    for (n = 0; n < NUM_LANDMARKS; n++) begin
      send_year(landmark_years[n]);
      hold_off($urandom_range(0, 2));
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_offset(phase_offsets[phase]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 20);
        for (n = 0; n < burst && sent < ITEMS_PER_PHASE; n++) begin
          send_year(random_year());
          sent++;
        end
        // Gap after a burst: none, short, long enough to land anywhere in the
        // block's busy window, or a full drain.
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          // keep start high, next burst follows directly
        end else if (pick < 7) begin
          hold_off($urandom_range(1, 15));
        end else if (pick < 9) begin
          hold_off($urandom_range(1, 60));
        end else begin
          wait_dates_drained();
        end
      end
    end

    wait_dates_drained();
    // Catch any stray strobe after the last expected result.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && dates_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
